// ----- src/gibs_pkg.sv -----
// Package with shared types and constants for the greedy IoU box suppression core.
`timescale 1ns / 1ps
package gibs_pkg;

    localparam int MaxBoxes = 64;
    localparam int IdxW     = $clog2(MaxBoxes);
    localparam int CntW     = $clog2(MaxBoxes + 1);
    localparam int CornerW  = 64;
    localparam int ScW      = 24;

    typedef logic signed [15:0] coord_t;
    typedef logic [IdxW-1:0]    idx_t;
    typedef logic [CntW-1:0]    cnt_t;

    // Main sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SEL_RD,
        ST_SEL_LD,
        ST_PAIR_RD,
        ST_PAIR_CHK,
        ST_PAIR_TEST,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    // Request to the shared overlap unit and its answer.
    typedef struct packed {
        logic           start;
        logic [63:0]    box_a;
        logic [63:0]    box_b;
        logic [15:0]    thr;
    } iou_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } iou_rsp_t;

endpackage

// ----- src/greedy_iou_box_suppression_core.sv -----
// Top level of the greedy IoU box suppression core: loader, selector, suppressor, emitter.
//
//  channel | direction | handshake      | payload
//  box in  | input     | start / busy   | left top right bottom score box_class last_box
//  config  | input     | cfg_valid/rdy  | cfg_data (overlap threshold)
//  result  | output    | result_valid   | out_* last_result overflow
//
// Boxes are accepted while busy is low. After the last box, each kept box costs a scan
// of the stored boxes for the best remaining score, a load of it, a pass over the
// stored boxes with an overlap test of each unsettled one on the shared overlap unit,
// and its presentation; a final clear state closes the set.
// Reset clears the control state, the count and the overflow flag; each box's
// suppressed flag is cleared as the box is loaded.
// The receiver cannot stall: each result stands for one cycle under result_valid.
`timescale 1ns / 1ps
module greedy_iou_box_suppression_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gibs_pkg::coord_t    left,
    input  gibs_pkg::coord_t    top,
    input  gibs_pkg::coord_t    right,
    input  gibs_pkg::coord_t    bottom,
    input  logic [15:0]         score,
    input  logic [7:0]          box_class,
    input  logic                last_box,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    output logic                result_valid,
    output gibs_pkg::coord_t    out_left,
    output gibs_pkg::coord_t    out_top,
    output gibs_pkg::coord_t    out_right,
    output gibs_pkg::coord_t    out_bottom,
    output logic [15:0]         out_score,
    output logic [7:0]          out_class,
    output logic                last_result,
    output logic                overflow
);
    import gibs_pkg::*;

    state_t              state_reg, state_next;
    cnt_t                count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [15:0]         thr_reg;
    cnt_t                k_reg, k_next;
    idx_t                best_reg, best_next;
    logic [15:0]         best_sc_reg, best_sc_next;
    logic                found_reg, found_next;
    cnt_t                remain_reg, remain_next;
    logic [63:0]         cur_box_reg, cur_box_next;
    logic [ScW-1:0]      cur_sc_reg, cur_sc_next;

    logic                c_we;
    idx_t                c_waddr, c_raddr;
    logic [63:0]         c_wdata, c_rdata;
    logic [ScW-1:0]      s_wdata, s_rdata;
    logic                d_we;
    idx_t                d_waddr;
    logic [0:0]          d_wdata, d_rdata;
    iou_req_t            ireq;
    iou_rsp_t            irsp;
    logic                accept;

    assign accept = start && !busy;

    gibs_ram #(.Width(CornerW), .Depth(MaxBoxes)) u_corners (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );
    gibs_ram #(.Width(ScW), .Depth(MaxBoxes)) u_score (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(s_wdata),
        .raddr(c_raddr), .rdata(s_rdata)
    );
    // One flag per box: set once the box is kept or suppressed.
    gibs_ram #(.Width(1), .Depth(MaxBoxes)) u_settled (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(c_raddr), .rdata(d_rdata)
    );
    gibs_iou_unit u_iou (.clk(clk), .rst_n(rst_n), .req(ireq), .rsp(irsp));

    assign c_wdata = {bottom, right, top, left};
    assign s_wdata = {box_class, score};
    assign c_waddr = count_reg[IdxW-1:0];
    assign c_we    = accept && (count_reg < cnt_t'(MaxBoxes));

    // Configuration write, taken only between sets.
    assign cfg_ready = (state_reg == ST_LOAD);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd32768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        k_next       = k_reg;
        best_next    = best_reg;
        best_sc_next = best_sc_reg;
        found_next   = found_reg;
        remain_next  = remain_reg;
        cur_box_next = cur_box_reg;
        cur_sc_next  = cur_sc_reg;
        c_raddr      = '0;
        d_we         = 1'b0;
        d_waddr      = '0;
        d_wdata      = 1'b0;
        ireq.start   = 1'b0;
        ireq.box_a   = cur_box_reg;
        ireq.box_b   = c_rdata;
        ireq.thr     = thr_reg;
        busy         = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    if (count_reg < cnt_t'(MaxBoxes))
                    begin
                        count_next = count_reg + 1'b1;
                        d_we       = 1'b1;
                        d_waddr    = count_reg[IdxW-1:0];
                        d_wdata    = 1'b0;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_box)
                    begin
                        k_next     = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            // Scan for the highest unsettled score; ties keep the earlier box.
            ST_SCAN_RD:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = ST_SEL_RD;
                end
                else
                begin
                    c_raddr    = k_reg[IdxW-1:0];
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (!d_rdata[0] && (!found_reg || s_rdata[15:0] > best_sc_reg))
                begin
                    best_next    = k_reg[IdxW-1:0];
                    best_sc_next = s_rdata[15:0];
                    found_next   = 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = ST_SCAN_RD;
            end
            // Keep the best box: mark it settled and load its payload.
            ST_SEL_RD:
            begin
                c_raddr    = best_reg;
                d_we       = 1'b1;
                d_waddr    = best_reg;
                d_wdata    = 1'b1;
                state_next = ST_SEL_LD;
            end
            ST_SEL_LD:
            begin
                cur_box_next = c_rdata;
                cur_sc_next  = s_rdata;
                k_next       = '0;
                remain_next  = '0;
                state_next   = ST_PAIR_RD;
            end
            // Test the kept box against every unsettled box.
            ST_PAIR_RD:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    c_raddr    = k_reg[IdxW-1:0];
                    state_next = ST_PAIR_CHK;
                end
            end
            ST_PAIR_CHK:
            begin
                if (d_rdata[0])
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_PAIR_RD;
                end
                else
                begin
                    ireq.start = 1'b1;
                    state_next = ST_PAIR_TEST;
                end
            end
            ST_PAIR_TEST:
            begin
                if (irsp.done)
                begin
                    if (irsp.hit)
                    begin
                        d_we    = 1'b1;
                        d_waddr = k_reg[IdxW-1:0];
                        d_wdata = 1'b1;
                    end
                    else
                    begin
                        remain_next = remain_reg + 1'b1;
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = ST_PAIR_RD;
                end
            end
            // Present the kept box for one cycle, then look for the next one or clear the set.
            ST_EMIT:
            begin
                if (remain_reg == '0)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    k_next     = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_CLEAR:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            k_reg      <= '0;
            found_reg  <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            k_reg      <= k_next;
            found_reg  <= found_next;
            remain_reg <= remain_next;
        end
    end

    // Index and payload holding registers.
    always_ff @(posedge clk)
    begin
        best_reg    <= best_next;
        best_sc_reg <= best_sc_next;
        cur_box_reg <= cur_box_next;
        cur_sc_reg  <= cur_sc_next;
    end

    // Result strobe for one cycle per kept box.
    assign result_valid = (state_reg == ST_EMIT);
    assign out_left     = cur_box_reg[15:0];
    assign out_top      = cur_box_reg[31:16];
    assign out_right    = cur_box_reg[47:32];
    assign out_bottom   = cur_box_reg[63:48];
    assign out_score    = cur_sc_reg[15:0];
    assign out_class    = cur_sc_reg[23:16];
    assign last_result  = (remain_reg == '0);
    assign overflow     = ovf_reg;

    // A result only appears while emitting.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> state_reg == ST_EMIT)
        else $error("result strobe outside emit phase");
    // The store never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MaxBoxes))
        else $error("box count above capacity");
    // After a set ends the store is empty again.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> count_reg == '0 && !ovf_reg)
        else $error("set state not cleared");
    // Configuration is only taken while boxes can be loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("configuration ready while busy");
    // A finished overlap test always returns to the pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR_TEST && irsp.done) |=> state_reg == ST_PAIR_RD)
        else $error("overlap test result not consumed");

endmodule

// ----- src/gibs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gibs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/gibs_iou_unit.sv -----
// Shared multi-cycle overlap test: one multiplier for the areas, plus a threshold multiplier.
`timescale 1ns / 1ps
module gibs_iou_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  gibs_pkg::iou_req_t req,
    output gibs_pkg::iou_rsp_t rsp
);
    import gibs_pkg::*;

    // Step codes of the unit.
    typedef enum logic [2:0] {
        U_IDLE, U_GEOM, U_AREA_A, U_AREA_B, U_INTER, U_LHS, U_RHS, U_CMP
    } ustep_t;

    ustep_t              step_reg, step_next;
    logic signed [17:0]  wa_reg, ha_reg, wb_reg, hb_reg, wi_reg, hi_reg;
    logic signed [35:0]  area_a_reg, area_b_reg, inter_reg;
    logic signed [37:0]  uni_reg;
    logic [52:0]         lhs_reg;
    logic [54:0]         rhs_reg;
    logic [15:0]         thr_reg;
    logic [63:0]         a_reg, b_reg;
    logic                hit_reg, done_reg;

    logic signed [17:0]  al, at, ar, ab, bl, bt, br, bb;
    logic signed [17:0]  x1, y1, x2, y2, w, h;
    logic signed [17:0]  mul_a, mul_b;
    logic signed [35:0]  mul_p;
    logic signed [37:0]  uni_sum;

    assign al = 18'(signed'(a_reg[15:0]));
    assign at = 18'(signed'(a_reg[31:16]));
    assign ar = 18'(signed'(a_reg[47:32]));
    assign ab = 18'(signed'(a_reg[63:48]));
    assign bl = 18'(signed'(b_reg[15:0]));
    assign bt = 18'(signed'(b_reg[31:16]));
    assign br = 18'(signed'(b_reg[47:32]));
    assign bb = 18'(signed'(b_reg[63:48]));
    assign x1 = (al > bl) ? al : bl;
    assign y1 = (at > bt) ? at : bt;
    assign x2 = (ar < br) ? ar : br;
    assign y2 = (ab < bb) ? ab : bb;
    assign w  = x2 - x1;
    assign h  = y2 - y1;

    // The shared signed multiplier for the three area products.
    always_comb
    begin
        mul_a = wa_reg;
        mul_b = ha_reg;
        unique case (step_reg)
            U_AREA_B:
            begin
                mul_a = wb_reg;
                mul_b = hb_reg;
            end
            U_INTER:
            begin
                mul_a = wi_reg;
                mul_b = hi_reg;
            end
            default:
            begin
                mul_a = wa_reg;
                mul_b = ha_reg;
            end
        endcase
    end
    assign mul_p   = mul_a * mul_b;
    assign uni_sum = 38'(area_a_reg) + 38'(area_b_reg) - 38'(inter_reg);

    // Step sequencing.
    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            U_IDLE:   if (req.start) step_next = U_GEOM;
            U_GEOM:   step_next = U_AREA_A;
            U_AREA_A: step_next = U_AREA_B;
            U_AREA_B: step_next = U_INTER;
            U_INTER:  step_next = U_LHS;
            U_LHS:    step_next = U_RHS;
            U_RHS:    step_next = U_CMP;
            U_CMP:    step_next = U_IDLE;
            default:  step_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= U_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= (step_reg == U_CMP);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (step_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    a_reg   <= req.box_a;
                    b_reg   <= req.box_b;
                    thr_reg <= req.thr;
                end
            end
            U_GEOM:
            begin
                wa_reg <= ar - al;
                ha_reg <= ab - at;
                wb_reg <= br - bl;
                hb_reg <= bb - bt;
                wi_reg <= w[17] ? '0 : w;
                hi_reg <= h[17] ? '0 : h;
            end
            U_AREA_A: area_a_reg <= mul_p;
            U_AREA_B: area_b_reg <= mul_p;
            U_INTER:  inter_reg  <= mul_p;
            U_LHS:
            begin
                uni_reg <= uni_sum;
                lhs_reg <= 53'(unsigned'(inter_reg)) << 16;
            end
            U_RHS:    rhs_reg <= 55'(thr_reg) * 55'(unsigned'(uni_reg[36:0]));
            U_CMP:
            begin
                hit_reg <= !uni_reg[37] && (uni_reg != '0)
                           && (55'(lhs_reg) > rhs_reg);
            end
            default:  ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;

endmodule
